/* design/whp_pkg.sv */
// Shared types, status codes and tag constants for the WAV header parser.
// No dependencies.
package whp_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_RIFF  = 3'd1;
    localparam logic [2:0] ERR_WAVE  = 3'd2;
    localparam logic [2:0] ERR_FMT   = 3'd3;
    localparam logic [2:0] ERR_FLEN  = 3'd4;
    localparam logic [2:0] ERR_BRATE = 3'd5;
    localparam logic [2:0] ERR_ALIGN = 3'd6;
    localparam logic [2:0] ERR_DATA  = 3'd7;

    localparam logic [31:0] FMT_CHUNK_LEN = 32'd16;

    typedef enum logic [1:0] {
        TAG_RIFF = 2'd0,
        TAG_WAVE = 2'd1,
        TAG_FMT  = 2'd2,
        TAG_DATA = 2'd3
    } tag_sel_t;

    localparam logic [7:0] TAG_BYTES [4][4] = '{
        '{8'h52, 8'h49, 8'h46, 8'h46},
        '{8'h57, 8'h41, 8'h56, 8'h45},
        '{8'h66, 8'h6D, 8'h74, 8'h20},
        '{8'h64, 8'h61, 8'h74, 8'h61}
    };

    // Header fields in stream order
    typedef enum logic [3:0] {
        S_RIFF,
        S_SIZE,
        S_WAVE,
        S_FMT,
        S_FLEN,
        S_FORMAT,
        S_CHAN,
        S_RATE,
        S_BRATE,
        S_ALIGN,
        S_BITS,
        S_DATA,
        S_DSIZE
    } phase_t;

    typedef struct packed {
        logic       accept;
        logic       tag_chk;
        tag_sel_t   tag_sel;
        logic [2:0] tag_code;
        logic       gather;
        logic [1:0] idx;
        logic       ld_flen;
        logic       ld_format;
        logic       ld_chan;
        logic       ld_rate;
        logic       ld_brate;
        logic       ld_align;
        logic       ld_bits;
        logic       emit;
    } whp_cmd_t;

    typedef struct packed {
        logic out_full;
    } whp_sts_t;

    function automatic logic [7:0] tag_byte(tag_sel_t sel, logic [1:0] idx);
        return TAG_BYTES[sel][idx];
    endfunction

endpackage

/* design/whp_ctrl.sv */
// Controller for the WAV header parser: walks the header field by field.
// Depends on whp_pkg.
module whp_ctrl
    import whp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     m_ready,
    input  whp_sts_t sts,
    output whp_cmd_t cmd
);

    phase_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx;
    logic       field_done;
    logic       accept;

    always_comb begin
        unique case (state_reg)
            S_FORMAT, S_CHAN, S_ALIGN, S_BITS: last_idx = 2'd1;
            default:                            last_idx = 2'd3;
        endcase
    end

    assign field_done = (idx_reg == last_idx);
    assign s_ready    = !(state_reg == S_DSIZE && field_done && sts.out_full && !m_ready);
    assign accept     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RIFF;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        if (accept) begin
            if (field_done) begin
                idx_next = 2'd0;
                unique case (state_reg)
                    S_RIFF:   state_next = S_SIZE;
                    S_SIZE:   state_next = S_WAVE;
                    S_WAVE:   state_next = S_FMT;
                    S_FMT:    state_next = S_FLEN;
                    S_FLEN:   state_next = S_FORMAT;
                    S_FORMAT: state_next = S_CHAN;
                    S_CHAN:   state_next = S_RATE;
                    S_RATE:   state_next = S_BRATE;
                    S_BRATE:  state_next = S_ALIGN;
                    S_ALIGN:  state_next = S_BITS;
                    S_BITS:   state_next = S_DATA;
                    S_DATA:   state_next = S_DSIZE;
                    S_DSIZE:  state_next = S_RIFF;
                    default:  state_next = S_RIFF;
                endcase
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    // Commands
    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.idx      = idx_reg;
        cmd.tag_sel  = TAG_RIFF;
        cmd.tag_code = ERR_NONE;
        unique case (state_reg)
            S_RIFF: begin
                cmd.tag_chk  = 1'b1;
                cmd.tag_sel  = TAG_RIFF;
                cmd.tag_code = ERR_RIFF;
            end
            S_SIZE: begin
            end
            S_WAVE: begin
                cmd.tag_chk  = 1'b1;
                cmd.tag_sel  = TAG_WAVE;
                cmd.tag_code = ERR_WAVE;
            end
            S_FMT: begin
                cmd.tag_chk  = 1'b1;
                cmd.tag_sel  = TAG_FMT;
                cmd.tag_code = ERR_FMT;
            end
            S_FLEN: begin
                cmd.gather  = 1'b1;
                cmd.ld_flen = field_done;
            end
            S_FORMAT: begin
                cmd.gather    = 1'b1;
                cmd.ld_format = field_done;
            end
            S_CHAN: begin
                cmd.gather  = 1'b1;
                cmd.ld_chan = field_done;
            end
            S_RATE: begin
                cmd.gather  = 1'b1;
                cmd.ld_rate = field_done;
            end
            S_BRATE: begin
                cmd.gather   = 1'b1;
                cmd.ld_brate = field_done;
            end
            S_ALIGN: begin
                cmd.gather   = 1'b1;
                cmd.ld_align = field_done;
            end
            S_BITS: begin
                cmd.gather  = 1'b1;
                cmd.ld_bits = field_done;
            end
            S_DATA: begin
                cmd.tag_chk  = 1'b1;
                cmd.tag_sel  = TAG_DATA;
                cmd.tag_code = ERR_DATA;
            end
            S_DSIZE: begin
                cmd.gather = 1'b1;
                cmd.emit   = field_done;
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/whp_datapath.sv */
// Datapath for the WAV header parser: field assembly, checks, products
// and the result register. Depends on whp_pkg.
module whp_datapath
    import whp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  whp_cmd_t    cmd,
    output whp_sts_t    sts,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_audio_format,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_sample_rate,
    output logic [15:0] m_sample_bits,
    output logic [31:0] m_data_size
);

    logic [31:0] field_shift_reg, field_shift_next;
    logic [2:0]  first_error_reg, first_error_next;
    logic        data_bad_reg, data_bad_next;
    logic        m_valid_reg, m_valid_next;
    logic [15:0] format_reg, chan_reg, align_reg, bits_reg;
    logic [31:0] rate_reg, brate_reg;
    logic [31:0] prod1_reg, prod2_reg, align_prod_reg;
    logic [2:0]  status_reg, status_next;
    logic [15:0] out_format_reg, out_chan_reg, out_bits_reg;
    logic [31:0] out_rate_reg, out_size_reg;
    logic        tag_miss;
    logic        rate_bad, align_bad;

    assign tag_miss = (tag_byte(cmd.tag_sel, cmd.idx) != s_in_byte);

    always_comb begin
        field_shift_next = field_shift_reg;
        if (cmd.idx == 2'd0) begin
            field_shift_next = {24'd0, s_in_byte};
        end else begin
            field_shift_next[{cmd.idx, 3'b000} +: BYTE_W] = s_in_byte;
        end
    end

    assign rate_bad  = (brate_reg != {3'd0, prod2_reg[31:3]});
    assign align_bad = ({16'd0, align_reg} != {3'd0, align_prod_reg[31:3]});

    always_comb begin
        first_error_next = first_error_reg;
        data_bad_next    = data_bad_reg;
        if (cmd.accept) begin
            if (cmd.tag_chk && tag_miss) begin
                if (cmd.tag_code == ERR_DATA) begin
                    data_bad_next = 1'b1;
                end else if (first_error_reg == ERR_NONE) begin
                    first_error_next = cmd.tag_code;
                end
            end
            if (cmd.ld_flen && first_error_reg == ERR_NONE
                && field_shift_next != FMT_CHUNK_LEN) begin
                first_error_next = ERR_FLEN;
            end
            if (cmd.emit) begin
                first_error_next = ERR_NONE;
                data_bad_next    = 1'b0;
            end
        end
    end

    // Rate and align errors are resolved late; priority follows stream order.
    always_comb begin
        if (first_error_reg != ERR_NONE) begin
            status_next = first_error_reg;
        end else if (rate_bad) begin
            status_next = ERR_BRATE;
        end else if (align_bad) begin
            status_next = ERR_ALIGN;
        end else if (data_bad_reg) begin
            status_next = ERR_DATA;
        end else begin
            status_next = ERR_NONE;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.accept && cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_error_reg <= ERR_NONE;
            data_bad_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            first_error_reg <= first_error_next;
            data_bad_reg    <= data_bad_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && cmd.gather) begin
            field_shift_reg <= field_shift_next;
        end
        if (cmd.accept && cmd.ld_format) format_reg <= field_shift_next[15:0];
        if (cmd.accept && cmd.ld_chan)   chan_reg   <= field_shift_next[15:0];
        if (cmd.accept && cmd.ld_rate)   rate_reg   <= field_shift_next;
        if (cmd.accept && cmd.ld_brate)  brate_reg  <= field_shift_next;
        if (cmd.accept && cmd.ld_align)  align_reg  <= field_shift_next[15:0];
        if (cmd.accept && cmd.ld_bits)   bits_reg   <= field_shift_next[15:0];
        prod1_reg      <= 32'(chan_reg * rate_reg);
        prod2_reg      <= 32'(prod1_reg * bits_reg);
        align_prod_reg <= 32'(chan_reg * bits_reg);
        if (cmd.accept && cmd.emit) begin
            status_reg     <= status_next;
            out_format_reg <= format_reg;
            out_chan_reg   <= chan_reg;
            out_rate_reg   <= rate_reg;
            out_bits_reg   <= bits_reg;
            out_size_reg   <= field_shift_next;
        end
    end

    assign sts.out_full     = m_valid_reg;
    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_audio_format   = out_format_reg;
    assign m_channel_count  = out_chan_reg;
    assign m_sample_rate    = out_rate_reg;
    assign m_sample_bits    = out_bits_reg;
    assign m_data_size      = out_size_reg;

endmodule

/* design/wav_header_parser.sv */
// Parses a canonical 44-byte RIFF/WAVE header, one byte per word, and returns
// one result word per header. Each byte takes one clock; the input stalls only
// when the last header byte arrives while the previous result is still
// untaken. Byte rate and block align are checked by a two-stage multiplier
// chain that finishes while the data tag and size bytes stream in. Status
// reports the first error in stream order; the field values are always the
// ones assembled from the bytes. Depends on whp_pkg, whp_ctrl, whp_datapath.
module wav_header_parser
    import whp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_audio_format,
    output logic [15:0] m_channel_count,
    output logic [31:0] m_sample_rate,
    output logic [15:0] m_sample_bits,
    output logic [31:0] m_data_size
);

    whp_cmd_t cmd;
    whp_sts_t sts;

    whp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    whp_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_audio_format  (m_audio_format),
        .m_channel_count (m_channel_count),
        .m_sample_rate   (m_sample_rate),
        .m_sample_bits   (m_sample_bits),
        .m_data_size     (m_data_size)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty result register");

    a_result_from_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && cmd.emit))
        else $error("result raised without final header byte");

    a_emit_only_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && cmd.emit) |=> m_valid)
        else $error("final header byte did not load a result");
`endif

endmodule
